@@ hdl/mse_loss_with_gradient_defines.svh @@
// Assertion macros for the mse_loss_with_gradient checker.
// No dependencies; taken in by `include where assertions are written.
`ifndef MSE_LOSS_WITH_GRADIENT_DEFINES_SVH
`define MSE_LOSS_WITH_GRADIENT_DEFINES_SVH

// Check that is switched off while reset is high.
`define MLG_CHECK(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("mse_loss_with_gradient: check failed");

// Check that also covers the reset cycles.
`define MLG_CHECK_RESET(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("mse_loss_with_gradient: reset check failed");

`endif

@@ hdl/mlg_pkg.sv @@
// Shared constants and types for the MSE loss and gradient block.
// No dependencies.
`default_nettype none

package mlg_pkg;

   localparam int MAX_LENGTH  = 1024;
   localparam int COUNT_W     = $clog2(MAX_LENGTH);
   localparam int LEN_W       = 11;
   localparam int INV_W       = 17;
   localparam int IN_W        = 16;
   localparam int DIFF_W      = IN_W + 1;
   localparam int SUM_W       = 43;
   localparam int SUM_LO_W    = 22;
   localparam int GRAD_W      = 18;
   localparam int COST_W      = 32;

   // shared multiplier: signed A by signed B, one registered product
   localparam int MUL_A_W     = SUM_LO_W + 1;
   localparam int MUL_B_W     = INV_W + 1;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

   localparam int CSR_DATA_W  = INV_W;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_VECTOR_LENGTH = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_LENGTH    = CSR_INDEX_W'(1);

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);
   localparam logic [INV_W-1:0] INV_RESET = INV_W'(65536);

   typedef struct packed {
      logic                       en;
      logic signed [MUL_A_W-1:0]  a;
      logic signed [MUL_B_W-1:0]  b;
   } mul_req_type;

endpackage

`default_nettype wire

@@ hdl/mlg_mul.sv @@
// Shared signed multiplier with a registered, load-enabled product.
// Depends on mlg_pkg.
`default_nettype none

module mlg_mul
   import mlg_pkg::*;
(
   input  wire logic                       clock,
   input  wire mul_req_type                mul_req,
   output logic signed [MUL_P_W-1:0]       prod_ff
);

   logic signed [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(mul_req.a) * MUL_P_W'(mul_req.b);

   // product holds while no operation is issued
   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/mse_loss_with_gradient.sv @@
// Top level of the streaming MSE loss and gradient block.
// Depends on mlg_pkg and mlg_mul.
//
// Use: each req item carries one predicted and one target element (signed
// Q4.12). Every item gives one rsp item: the gradient 2*(p-t)*inv_length>>16,
// saturated to 18 bits, plus the cost and cost_valid. The cost field is the
// mean squared error (Q8.24, saturated) on the element that completes a
// vector of vector_length elements, and zero on every other element.
// Sequence: one shared multiplier does the square, then the gradient product,
// then on a closing element the two halves of the 43-bit sum by inv_length.
// An ordinary element passes states SQ, GR and GD, a closing element SQ, GR,
// C0, C1 and C2; the last state loads the result into the output register.
// req_stall is high while an item is at work. Stall: the result waits in the
// output register; the sequencer holds its last step (multiplier product
// frozen) until that register is free. Reset (synchronous, active high)
// empties the output, clears sum and count and restores vector_length = 1
// and inv_length = 65536. csr writes take effect at once; the user must make
// them only while the block is idle, which the block itself does not enforce.
`default_nettype none

module mse_loss_with_gradient
   import mlg_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [IN_W-1:0]   req_predicted,
   input  wire logic signed [IN_W-1:0]   req_target_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [GRAD_W-1:0]      rsp_gradient,
   output logic [COST_W-1:0]             rsp_cost,
   output logic                          rsp_cost_valid,
   input  wire logic                     csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SQ_W       = 2 * DIFF_W;
   localparam int GRAD_SHIFT = 16;
   localparam int GS_W       = MUL_P_W - GRAD_SHIFT;
   localparam int HI_P_W     = SUM_W - SUM_LO_W + INV_W;
   localparam int LO_P_W     = SUM_LO_W + INV_W;
   localparam int FULL_W     = SUM_W + INV_W;
   localparam int COST_SHIFT = 16;

   localparam logic signed [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
   localparam logic signed [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,   // waiting for an item
      ST_SQ,     // issue diff*diff
      ST_GR,     // accumulate square, issue 2*diff*inv
      ST_GD,     // gradient ready, hand over ordinary result
      ST_C0,     // keep gradient, issue low sum half
      ST_C1,     // keep low product, issue high sum half
      ST_C2      // form cost, hand over closing result
   } state_type;

   state_type                   state_ff;

   // configuration
   logic [LEN_W-1:0]            vector_length_ff;
   logic [INV_W-1:0]            inv_length_ff;

   // datapath state
   logic signed [DIFF_W-1:0]    diff_ff;
   logic [SUM_W-1:0]            square_sum_ff;
   logic [COUNT_W-1:0]          element_count_ff;
   logic signed [GRAD_W-1:0]    grad_ff;
   logic [LO_P_W-1:0]           lo_ff;

   // output register
   logic                        rsp_valid_ff;
   logic signed [GRAD_W-1:0]    rsp_gradient_ff;
   logic [COST_W-1:0]           rsp_cost_ff;
   logic                        rsp_cost_valid_ff;

   logic signed [DIFF_W-1:0]    diff_in;
   mul_req_type                 mul_req;
   logic signed [MUL_P_W-1:0]   prod_ff;
   logic [SUM_W:0]              sum_add;
   logic [SUM_W-1:0]            square_sum_in;
   logic [LEN_W-1:0]            eff_len;
   logic [LEN_W-1:0]            count_next;
   logic                        last;
   logic signed [GS_W-1:0]      gshift;
   logic                        grad_ovf;
   logic signed [GRAD_W-1:0]    grad_in;
   logic [FULL_W-1:0]           cost_full;
   logic [COST_W-1:0]           cost_in;
   logic                        out_free;
   logic                        rsp_load;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         vector_length_ff <= LEN_RESET;
         inv_length_ff    <= INV_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_VECTOR_LENGTH: vector_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_INV_LENGTH:    inv_length_ff    <= csr_wdata[INV_W-1:0];
            default: ;         // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------- datapath
   assign diff_in = DIFF_W'(req_predicted) - DIFF_W'(req_target_value);

   // operand selection for the shared multiplier
   always_comb begin
      mul_req.en = 1'b0;
      mul_req.a  = '0;
      mul_req.b  = $signed({1'b0, inv_length_ff});
      unique case (state_ff)
         ST_SQ: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(diff_ff);
            mul_req.b  = MUL_B_W'(diff_ff);
         end
         ST_GR: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'($signed({diff_ff, 1'b0}));
         end
         ST_C0: begin
            mul_req.en = 1'b1;
            mul_req.a  = $signed(MUL_A_W'(square_sum_ff[SUM_LO_W-1:0]));
         end
         ST_C1: begin
            mul_req.en = 1'b1;
            mul_req.a  = $signed(MUL_A_W'(square_sum_ff[SUM_W-1:SUM_LO_W]));
         end
         default: ;
      endcase
   end

   mlg_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod_ff (prod_ff)
   );

   // saturating accumulate of the square
   assign sum_add       = (SUM_W+1)'(square_sum_ff) + (SUM_W+1)'(prod_ff[SQ_W-1:0]);
   assign square_sum_in = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

   // effective length: zero acts as one, clamp at the maximum
   always_comb begin
      priority if (vector_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (vector_length_ff > LEN_W'(MAX_LENGTH)) begin
         eff_len = LEN_W'(MAX_LENGTH);
      end else begin
         eff_len = vector_length_ff;
      end
   end

   assign count_next = LEN_W'(element_count_ff) + LEN_W'(1);
   assign last       = (count_next >= eff_len);

   // gradient: arithmetic shift floors, then clamp to 18 bits
   assign gshift   = GS_W'(prod_ff >>> GRAD_SHIFT);
   assign grad_ovf = (gshift[GS_W-1:GRAD_W-1] != '0) && (gshift[GS_W-1:GRAD_W-1] != '1);
   assign grad_in  = grad_ovf ? (gshift[GS_W-1] ? GRAD_MIN : GRAD_MAX)
                              : gshift[GRAD_W-1:0];

   // cost from the two partial products, truncate then saturate
   assign cost_full = (FULL_W'(prod_ff[HI_P_W-1:0]) << SUM_LO_W) + FULL_W'(lo_ff);
   assign cost_in   = (cost_full[FULL_W-1:COST_SHIFT+COST_W] != '0) ? {COST_W{1'b1}}
                      : cost_full[COST_SHIFT+COST_W-1:COST_SHIFT];

   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // output register takes a new item this cycle
   assign rsp_load  = out_free && ((state_ff == ST_GD) || (state_ff == ST_C2));

   // --------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         square_sum_ff    <= '0;
         element_count_ff <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  diff_ff  <= diff_in;
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               state_ff <= ST_GR;
            end
            ST_GR: begin
               square_sum_ff <= square_sum_in;
               if (last) begin
                  state_ff <= ST_C0;
               end else begin
                  element_count_ff <= count_next[COUNT_W-1:0];
                  state_ff         <= ST_GD;
               end
            end
            ST_GD: begin
               if (out_free) begin
                  rsp_gradient_ff   <= grad_in;
                  rsp_cost_ff       <= '0;
                  rsp_cost_valid_ff <= 1'b0;
                  state_ff          <= ST_IDLE;
               end
            end
            ST_C0: begin
               grad_ff  <= grad_in;
               state_ff <= ST_C1;
            end
            ST_C1: begin
               lo_ff    <= prod_ff[LO_P_W-1:0];
               state_ff <= ST_C2;
            end
            ST_C2: begin
               if (out_free) begin
                  rsp_gradient_ff   <= grad_ff;
                  rsp_cost_ff       <= cost_in;
                  rsp_cost_valid_ff <= 1'b1;
                  square_sum_ff     <= '0;
                  element_count_ff  <= '0;
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gradient   = rsp_gradient_ff;
   assign rsp_cost       = rsp_cost_ff;
   assign rsp_cost_valid = rsp_cost_valid_ff;

endmodule

`default_nettype wire

@@ hdl/mlg_checker.sv @@
// Port-level checks for mse_loss_with_gradient, bound to the top level.
// Depends on mlg_pkg and mse_loss_with_gradient_defines.svh.
`default_nettype none

`include "mse_loss_with_gradient_defines.svh"

module mlg_checker
   import mlg_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_stall,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire logic signed [GRAD_W-1:0] rsp_gradient,
   input  wire logic [COST_W-1:0]        rsp_cost,
   input  wire logic                     rsp_cost_valid
);

   // stalled result item stays and holds its payload
   `MLG_CHECK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gradient) && $stable(rsp_cost) && $stable(rsp_cost_valid))

   // cost field is zero unless the item closes a vector
   `MLG_CHECK(a_cost_zero, rsp_valid && !rsp_cost_valid |-> rsp_cost == '0)

   // one item at a time: busy right after an accept
   `MLG_CHECK(a_busy_after_accept, req_valid && !req_stall |=> req_stall)

   // after reset: output empty, input open
   `MLG_CHECK_RESET(a_reset_state, reset |=> !rsp_valid && !req_stall)

endmodule

bind mse_loss_with_gradient mlg_checker u_mlg_checker (.*);

`default_nettype wire

@@ verif/mlg_test_pkg.sv @@
// Scoreboard for the MSE loss and gradient test: a bit-exact predictor of each
// result item plus the queue of results still due. Depends on mlg_pkg.
package mlg_test_pkg;
   import mlg_pkg::*;

   typedef struct packed {
      logic signed [GRAD_W-1:0] gradient;
      logic [COST_W-1:0]        cost;
      logic                     cost_valid;
   } loss_result_type;

   class loss_scoreboard;
      logic [LEN_W-1:0]  vector_length;
      logic [INV_W-1:0]  inv_length;
      longint unsigned   square_sum;
      int unsigned       element_count;
      loss_result_type   due_results[$];
      int unsigned       mismatches;

      function new();
         vector_length = LEN_RESET;
         inv_length    = INV_RESET;
         square_sum    = 0;
         element_count = 0;
         mismatches    = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_VECTOR_LENGTH: vector_length = data[LEN_W-1:0];
            CSR_INV_LENGTH:    inv_length    = data[INV_W-1:0];
            default: ;
         endcase
      endfunction

      // Works out the result item for one element and updates sum and count.
      function void note_element(logic signed [IN_W-1:0] predicted,
                                 logic signed [IN_W-1:0] target_value);
         longint          diff;
         longint          inv_wide;
         longint          grad;
         longint unsigned sq;
         longint unsigned cost_wide;
         longint unsigned sum_limit;
         int unsigned     eff_length;
         loss_result_type res;
         diff      = longint'(predicted) - longint'(target_value);
         inv_wide  = inv_length;
         sum_limit = (64'd1 << SUM_W) - 1;
         // arithmetic shift on a signed value floors, as the block does
         grad = (2 * diff * inv_wide) >>> 16;
         if (grad > 131071) grad = 131071;
         if (grad < -131072) grad = -131072;
         sq = diff * diff;
         square_sum = square_sum + sq;
         if (square_sum > sum_limit) square_sum = sum_limit;
         eff_length = vector_length;
         if (eff_length == 0) eff_length = 1;
         if (eff_length > MAX_LENGTH) eff_length = MAX_LENGTH;
         res.gradient   = grad[GRAD_W-1:0];
         res.cost       = '0;
         res.cost_valid = 1'b0;
         if (element_count + 1 >= eff_length) begin
            cost_wide = (square_sum * longint'(inv_wide)) >> 16;
            if (cost_wide > 64'hFFFF_FFFF) cost_wide = 64'hFFFF_FFFF;
            res.cost       = cost_wide[COST_W-1:0];
            res.cost_valid = 1'b1;
            square_sum     = 0;
            element_count  = 0;
         end else begin
            element_count++;
         end
         due_results.push_back(res);
      endfunction

      function void check_result(logic signed [GRAD_W-1:0] gradient,
                                 logic [COST_W-1:0] cost, logic cost_valid);
         loss_result_type want;
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item: gradient %0d cost %0d cost_valid %0b",
                        gradient, cost, cost_valid);
            return;
         end
         want = due_results.pop_front();
         if (want.gradient !== gradient || want.cost !== cost ||
             want.cost_valid !== cost_valid) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: gradient exp %0d got %0d, cost exp %0d got %0d, %s %0b got %0b",
                        want.gradient, gradient, want.cost, cost,
                        "cost_valid exp", want.cost_valid, cost_valid);
         end
      endfunction

      function int unsigned pending();
         return due_results.size();
      endfunction
   endclass
endpackage

@@ verif/mse_loss_with_gradient_test.sv @@
// Self-checking test of mse_loss_with_gradient: directed corner items, then
// random vectors over many length settings. Depends on mlg_pkg, mlg_test_pkg.
module mse_loss_with_gradient_test;
   import mlg_pkg::*;
   import mlg_test_pkg::*;

   // unused register slots; writes there must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = CSR_INDEX_W'(3);

   localparam logic signed [IN_W-1:0] FULL_POS = 16'sh7FFF;
   localparam logic signed [IN_W-1:0] FULL_NEG = 16'sh8000;
   localparam int RANDOM_ITEMS = 360;
   localparam int TAIL_ITEMS   = 160;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 400000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [IN_W-1:0]    req_predicted = '0;
   logic signed [IN_W-1:0]    req_target_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [GRAD_W-1:0]  rsp_gradient;
   logic [COST_W-1:0]         rsp_cost;
   logic                      rsp_cost_valid;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   loss_scoreboard board;
   bit             no_idle = 1'b0;         // phase with back-to-back traffic
   bit             long_hold_pending = 1'b0;
   int unsigned    cycle_count = 0;

   mse_loss_with_gradient dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_predicted    (req_predicted),
      .req_target_value (req_target_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_gradient     (rsp_gradient),
      .rsp_cost         (rsp_cost),
      .rsp_cost_valid   (rsp_cost_valid),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Monitor. Samples pre-edge values at each rising edge, so register
   // writes, accepted elements and accepted results reach the scoreboard
   // in the order the block sees them.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable)
            board.write_register(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            board.note_element(req_predicted, req_target_value);
         if (rsp_valid && !rsp_stall)
            board.check_result(rsp_gradient, rsp_cost, rsp_cost_valid);
      end
   end

   // Result side. Draws a random stall before each item, none while no_idle
   // is set; once the main process asks, it holds off for a long stretch so
   // that the block backs up and raises req_stall.
   initial begin : result_sink
      int hold;
      while (reset) @(posedge clock);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 5);
         if (long_hold_pending) begin
            hold = LONG_HOLD;
            long_hold_pending = 1'b0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Offers one element after a random gap. Valid is left high on return so
   // that a following item with no gap keeps it high without a glitch.
   task automatic send_element(input logic signed [IN_W-1:0] predicted,
                               input logic signed [IN_W-1:0] target_value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_predicted    <= predicted;
      req_target_value <= target_value;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   function automatic logic signed [IN_W-1:0] draw_sample();
      case ($urandom_range(0, 7))
         0:       return FULL_POS;
         1:       return FULL_NEG;
         2:       return IN_W'($urandom_range(0, 63)) - IN_W'(32);
         default: return IN_W'($urandom);
      endcase
   endfunction

   // Random pair; heavy biases towards full-scale differences to push
   // the square sum and the cost towards saturation.
   task automatic send_random_element(input bit heavy);
      logic signed [IN_W-1:0] t;
      logic signed [IN_W-1:0] p;
      if (heavy && $urandom_range(0, 1) == 1) begin
         if ($urandom_range(0, 1) == 1) send_element(FULL_POS, FULL_NEG);
         else                           send_element(FULL_NEG, FULL_POS);
      end else begin
         t = draw_sample();
         if ($urandom_range(0, 3) == 0) p = t + IN_W'($urandom_range(0, 15)) - IN_W'(8);
         else                           p = draw_sample();
         send_element(p, t);
      end
   endtask

   // Leaves the enable high; the caller lowers it after its last write.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_wdata        <= data;
      @(posedge clock);
   endtask

   task automatic program_lengths(input logic [CSR_DATA_W-1:0] length,
                                  input logic [CSR_DATA_W-1:0] inverse);
      write_csr(CSR_VECTOR_LENGTH, length);
      write_csr(CSR_INV_LENGTH, inverse);
      csr_write_enable <= 1'b0;
   endtask

   // Stops offering and waits for every due result; registers are only
   // written once this returns. The first edge lets the monitor note the
   // element accepted at the edge the caller returned on.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int random_items;
      int length;
      int eff_length;
      int inverse;
      int count;
      int sel;
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings (one element per vector, inverse one): full-scale
      // differences both ways, zero, equal inputs, smallest negative step.
      send_element(FULL_POS, FULL_NEG);
      send_element(FULL_NEG, FULL_POS);
      send_element(16'sd0, 16'sd0);
      send_element(16'sd1234, 16'sd1234);
      send_element(-16'sd1, 16'sd0);
      drain();

      // Zero length acts as one; inverse above one saturates gradient and cost.
      program_lengths(CSR_DATA_W'(0), CSR_DATA_W'(131071));
      send_element(FULL_POS, FULL_NEG);
      send_element(FULL_NEG, FULL_POS);
      send_element(16'sd3, -16'sd4);
      drain();

      // Inverse of zero: gradient and cost both zero.
      program_lengths(CSR_DATA_W'(2), CSR_DATA_W'(0));
      send_element(FULL_POS, 16'sd100);
      send_element(-16'sd2000, FULL_POS);
      drain();

      // Length shortened mid-vector: five in with length eight, then length
      // three closes the vector on the very next element.
      program_lengths(CSR_DATA_W'(8), CSR_DATA_W'(8192));
      repeat (5) send_random_element(1'b0);
      drain();
      write_csr(CSR_VECTOR_LENGTH, CSR_DATA_W'(3));
      // spare slots are ignored; upper data bits beyond the length field drop
      write_csr(CSR_SPARE_LOW, CSR_DATA_W'(5));
      write_csr(CSR_SPARE_HIGH, '1);
      csr_write_enable <= 1'b0;
      send_element(16'sd4096, -16'sd4096);
      drain();
      write_csr(CSR_VECTOR_LENGTH, 17'h1_F802);
      write_csr(CSR_INV_LENGTH, CSR_DATA_W'(32768));
      csr_write_enable <= 1'b0;
      repeat (3) send_random_element(1'b0);
      drain();

      // Random vectors. Mostly short lengths with a matched inverse; the odd
      // phase has a zero length or a wild inverse. Element counts need not be
      // whole vectors, so partial sums can carry across length changes.
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 9);
         if (sel == 0)      length = 0;
         else if (sel <= 7) length = $urandom_range(1, 24);
         else               length = $urandom_range(25, 64);
         eff_length = (length == 0) ? 1 : length;
         case ($urandom_range(0, 9))
            0:       inverse = 0;
            1:       inverse = 131071;
            2:       inverse = $urandom_range(0, 131071);
            default: inverse = 65536 / eff_length;
         endcase
         program_lengths(CSR_DATA_W'(length), CSR_DATA_W'(inverse));
         no_idle = ($urandom_range(0, 3) == 0);
         count = eff_length * $urandom_range(1, 3) + $urandom_range(0, 2);
         repeat (count) send_random_element(1'b0);
         random_items += count;
         drain();
      end

      // Over-range length acts as the maximum, so a long run of pairs, about
      // half full-scale, stays inside one vector. The result side stalls for a long
      // stretch here so the block fills and stalls its input.
      program_lengths(CSR_DATA_W'(2047), CSR_DATA_W'(64));
      no_idle = 1'b0;
      long_hold_pending = 1'b1;
      repeat (TAIL_ITEMS) send_random_element(1'b1);
      drain();

      repeat (16) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/mlg_pkg.sv
hdl/mlg_mul.sv
hdl/mse_loss_with_gradient.sv
hdl/mlg_checker.sv
verif/mlg_test_pkg.sv
verif/mse_loss_with_gradient_test.sv
